/* rtl/lrip_pkg.sv */
// Shared constants, types and command record for the range image packetizer.
package lrip_pkg;

    localparam int LASERS_PER_BLOCK  = 32;
    localparam int BLOCKS_PER_PACKET = 12;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [15:0] MARK_LOWER = 16'heeff;
    localparam logic [15:0] MARK_UPPER = 16'hddff;
    localparam logic [7:0]  TAIL_BYTE  = 8'd30;
    localparam logic [15:0] RANGE_MAX  = 16'hffff;

    // byte positions within one item's output sequence
    localparam logic [3:0] STEP_MARK_LO  = 4'd0;
    localparam logic [3:0] STEP_MARK_HI  = 4'd1;
    localparam logic [3:0] STEP_ROT_LO   = 4'd2;
    localparam logic [3:0] STEP_ROT_HI   = 4'd3;
    localparam logic [3:0] STEP_RANGE_LO = 4'd4;
    localparam logic [3:0] STEP_RANGE_HI = 4'd5;
    localparam logic [3:0] STEP_INTEN    = 4'd6;
    localparam logic [3:0] STEP_TAIL_END = 4'd12;

    localparam logic REG_ROWS_MODE = 1'b0;

    typedef struct packed {
        logic        hdr;
        logic        upper;
        logic        tail;
        logic [15:0] rotation;
        logic [15:0] range;
        logic [7:0]  intensity;
    } t_cmd;

endpackage

/* rtl/lrip_pix_if.sv */
// Pixel input channel.
interface lrip_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] rotation;
    logic [15:0] distance_cm;
    logic [7:0]  intensity;
    logic        last_of_scan;

    modport source (output valid, rotation, distance_cm, intensity, last_of_scan,
                    input ready);
    modport sink (input valid, rotation, distance_cm, intensity, last_of_scan,
                  output ready);
endinterface

/* rtl/lrip_byte_if.sv */
// Packet byte output channel.
interface lrip_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_of_packet;
    logic       last_of_item;

    modport source (output valid, packet_byte, last_of_packet, last_of_item,
                    input ready);
    modport sink (input valid, packet_byte, last_of_packet, last_of_item,
                  output ready);
endinterface

/* rtl/lidar_range_image_packetizer.sv */
// Range image packetizer top level: APB config, front end, command queue, serializer.
// Pixels arrive in column order, laser index fastest, and leave as a lidar packet byte
// stream, one byte per cycle from the serializer's output register while o_byte.ready
// holds. A pixel is accepted every cycle while the four-entry command queue has room;
// its output is 3 bytes, 7 when it opens a block (marker and rotation), and 6 more when
// it closes a packet (six tail bytes, the last flagged last_of_packet). The byte
// serializer sets the sustained rate. rows_mode (address 0, reset 1) selects 64 lasers
// per column; write it only while idle.
module lidar_range_image_packetizer import lrip_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lrip_pix_if.sink    i_pix,
    lrip_byte_if.source o_byte
);

    logic r_rows_mode;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROWS_MODE) ? {31'd0, r_rows_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_mode <= 1'b1;
        end else if (psel && penable && pwrite && (paddr[2] == REG_ROWS_MODE)) begin
            r_rows_mode <= pwdata[0];
        end
    end

    lrip_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rows_mode (r_rows_mode),
        .i_pix       (i_pix),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    lrip_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head_cmd)
    );

    lrip_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );

endmodule

/* rtl/lrip_front.sv */
// Front end: accepts pixels, tracks laser/block position, builds byte commands.
module lrip_front import lrip_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rows_mode,
    lrip_pix_if.sink   i_pix,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [5:0]  r_laser, n_laser;
    logic [3:0]  r_block, n_block;
    logic [6:0]  col_len;
    logic [5:0]  li;
    logic [5:0]  pos;
    logic        upper;
    logic        blk_end;
    logic [3:0]  nb;
    logic        tail;
    logic [6:0]  li_inc;
    logic [18:0] range_full;
    logic [15:0] range_sat;

    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;

    assign col_len = i_rows_mode ? 7'(2 * LASERS_PER_BLOCK) : 7'(LASERS_PER_BLOCK);
    // a mode change can leave the index past the column end
    assign li      = ({1'b0, r_laser} >= col_len) ? 6'd0 : r_laser;
    assign upper   = {1'b0, li} >= 7'(LASERS_PER_BLOCK);
    assign pos     = upper ? (li - 6'(LASERS_PER_BLOCK)) : li;
    assign blk_end = pos == 6'(LASERS_PER_BLOCK - 1);
    assign nb      = r_block + 4'd1;
    assign tail    = blk_end && (nb >= 4'(BLOCKS_PER_PACKET));
    assign li_inc  = {1'b0, li} + 7'd1;

    // 5*d + 2 in 2 mm units
    assign range_full = {1'b0, i_pix.distance_cm, 2'b00} + {3'b000, i_pix.distance_cm} + 19'd2;
    assign range_sat  = (range_full[18:16] != 3'd0) ? RANGE_MAX : range_full[15:0];

    always_comb begin
        o_cmd.hdr       = pos == 6'd0;
        o_cmd.upper     = upper;
        o_cmd.tail      = tail;
        o_cmd.rotation  = i_pix.rotation;
        o_cmd.range     = range_sat;
        o_cmd.intensity = i_pix.intensity;

        n_laser = (li_inc >= col_len) ? 6'd0 : li_inc[5:0];
        n_block = r_block;
        if (blk_end) begin
            n_block = tail ? 4'd0 : nb;
        end
        if (i_pix.last_of_scan) begin
            n_laser = 6'd0;
            n_block = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_laser <= 6'd0;
            r_block <= 4'd0;
        end else if (o_push) begin
            r_laser <= n_laser;
            r_block <= n_block;
        end
    end

endmodule

/* rtl/lrip_fifo.sv */
// Short command queue between front end and byte serializer.
module lrip_fifo import lrip_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_full  = r_count == (FIFO_AW + 1)'(FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/lrip_back.sv */
// Back end: serializes each command into packet bytes through an output register.
module lrip_back import lrip_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_empty,
    input  t_cmd         i_cmd,
    output logic         o_pop,
    lrip_byte_if.source  o_byte
);

    t_cmd       r_cmd;
    logic       r_busy;
    logic [3:0] r_step;
    logic       r_out_valid;
    logic [7:0] r_byte;
    logic       r_lpkt;
    logic       r_litem;

    logic        take;
    logic        advance;
    logic        fin;
    logic [15:0] mark;
    logic [7:0]  cur_byte;

    assign take    = !r_out_valid || o_byte.ready;
    assign advance = r_busy && take;
    assign fin     = r_cmd.tail ? (r_step == STEP_TAIL_END) : (r_step == STEP_INTEN);
    assign o_pop   = !i_empty && (!r_busy || (advance && fin));
    assign mark    = r_cmd.upper ? MARK_UPPER : MARK_LOWER;

    always_comb begin
        case (r_step)
            STEP_MARK_LO:  cur_byte = mark[7:0];
            STEP_MARK_HI:  cur_byte = mark[15:8];
            STEP_ROT_LO:   cur_byte = r_cmd.rotation[7:0];
            STEP_ROT_HI:   cur_byte = r_cmd.rotation[15:8];
            STEP_RANGE_LO: cur_byte = r_cmd.range[7:0];
            STEP_RANGE_HI: cur_byte = r_cmd.range[15:8];
            STEP_INTEN:    cur_byte = r_cmd.intensity;
            default:       cur_byte = TAIL_BYTE;
        endcase
    end

    assign o_byte.valid          = r_out_valid;
    assign o_byte.packet_byte    = r_byte;
    assign o_byte.last_of_packet = r_lpkt;
    assign o_byte.last_of_item   = r_litem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= STEP_MARK_LO;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= i_cmd.hdr ? STEP_MARK_LO : STEP_RANGE_LO;
            end else if (advance) begin
                if (fin) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (advance) begin
            r_byte  <= cur_byte;
            r_lpkt  <= r_step == STEP_TAIL_END;
            r_litem <= fin;
        end
    end

endmodule
